FILE: rtl/ehc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehc_pkg
// Shared types, constants and tables for the early heading cost core.
// ----------------------------------------------------------------------------
package ehc_pkg;

	localparam int MAX_STEPS    = 10;
	localparam int CORDIC_ITERS = 20;
	localparam int CW           = 60;   // CORDIC datapath width
	localparam int POW_STAGES   = 7;    // exponent register allows up to 7
	localparam logic [26:0] TWO_PI_Q24 = 27'd105414357;

	typedef enum logic [2:0] {
		REG_ENABLE       = 3'd0,
		REG_TARGET_X     = 3'd1,
		REG_TARGET_Y     = 3'd2,
		REG_EARLY_STEPS  = 3'd3,
		REG_FORWARD_ONLY = 3'd4,
		REG_WEIGHT       = 3'd5,
		REG_EXPONENT     = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic        valid;
		logic        zero;      // force cost to zero
		logic        fwd_only;
		logic [3:0]  n;         // steps averaged, 0..MAX_STEPS (0 forces zero)
		logic [2:0]  power;
		logic [15:0] weight;
	} ctl_t;

	typedef logic [MAX_STEPS-1:0][15:0] yaw_vec_t;

	function automatic logic [31:0] atan_at(input int i);
		logic [31:0] t;
		case (i)
			0:       t = 32'h20000000;
			1:       t = 32'h12E4051E;
			2:       t = 32'h09FB385B;
			3:       t = 32'h051111D4;
			4:       t = 32'h028B0D43;
			5:       t = 32'h0145D7E1;
			6:       t = 32'h00A2F61E;
			7:       t = 32'h00517C55;
			8:       t = 32'h0028BE53;
			9:       t = 32'h00145F2F;
			10:      t = 32'h000A2F98;
			11:      t = 32'h000517CC;
			12:      t = 32'h00028BE6;
			13:      t = 32'h000145F3;
			14:      t = 32'h0000A2FA;
			15:      t = 32'h0000517D;
			16:      t = 32'h000028BE;
			17:      t = 32'h0000145F;
			18:      t = 32'h00000A30;
			19:      t = 32'h00000518;
			default: t = 32'h0;
		endcase
		return t;
	endfunction

	// floor(2^32 / n)
	function automatic logic [32:0] recip(input logic [3:0] n);
		logic [32:0] r;
		case (n)
			4'd1:    r = 33'h1_0000_0000;
			4'd2:    r = 33'h0_8000_0000;
			4'd3:    r = 33'h0_5555_5555;
			4'd4:    r = 33'h0_4000_0000;
			4'd5:    r = 33'h0_3333_3333;
			4'd6:    r = 33'h0_2AAA_AAAA;
			4'd7:    r = 33'h0_2492_4924;
			4'd8:    r = 33'h0_2000_0000;
			4'd9:    r = 33'h0_1C71_C71C;
			4'd10:   r = 33'h0_1999_9999;
			default: r = 33'h0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/ehc_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehc_cordic
// Pipelined vectoring CORDIC: bearing of (dx, dy) as a 16-bit binary angle.
// ----------------------------------------------------------------------------
module ehc_cordic (
	input  logic               clk,
	input  logic               arst_n,
	input  ehc_pkg::ctl_t      ctl_in,
	input  ehc_pkg::yaw_vec_t  yaw_in,
	input  logic signed [32:0] dx,
	input  logic signed [32:0] dy,
	output ehc_pkg::ctl_t      ctl_out,
	output ehc_pkg::yaw_vec_t  yaw_out,
	output logic [15:0]        bearing
);
	import ehc_pkg::*;

	logic signed [CW-1:0] x_s   [0:CORDIC_ITERS];
	logic signed [CW-1:0] y_s   [0:CORDIC_ITERS];
	logic [31:0]          ang_s [0:CORDIC_ITERS];
	logic                 z_s   [0:CORDIC_ITERS];
	yaw_vec_t             yaw_s [0:CORDIC_ITERS];
	ctl_t                 ctl_s [0:CORDIC_ITERS];

	logic signed [CW-1:0] xe, ye, x0, y0;
	logic [31:0]          a0;
	logic [31:0]          ang_rnd;

	always_comb begin
		xe = {{(CW-57){dx[32]}}, dx, 24'd0};
		ye = {{(CW-57){dy[32]}}, dy, 24'd0};
		if (dx[32]) begin
			// turn by a half turn into the right half plane
			x0 = -xe;
			y0 = -ye;
			a0 = 32'h8000_0000;
		end else begin
			x0 = xe;
			y0 = ye;
			a0 = 32'h0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s[0] <= '0;
		end else begin
			ctl_s[0] <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]   <= x0;
		y_s[0]   <= y0;
		ang_s[0] <= a0;
		z_s[0]   <= (dx == 33'sd0) && (dy == 33'sd0);
		yaw_s[0] <= yaw_in;
	end

	for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
		logic signed [CW-1:0] xsh, ysh;
		assign xsh = x_s[i] >>> i;
		assign ysh = y_s[i] >>> i;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_s[i+1] <= '0;
			end else begin
				ctl_s[i+1] <= ctl_s[i];
			end
		end

		always_ff @(posedge clk) begin
			if (y_s[i] >= 0) begin
				x_s[i+1]   <= x_s[i] + ysh;
				y_s[i+1]   <= y_s[i] - xsh;
				ang_s[i+1] <= ang_s[i] + atan_at(i);
			end else begin
				x_s[i+1]   <= x_s[i] - ysh;
				y_s[i+1]   <= y_s[i] + xsh;
				ang_s[i+1] <= ang_s[i] - atan_at(i);
			end
			z_s[i+1]   <= z_s[i];
			yaw_s[i+1] <= yaw_s[i];
		end
	end

	assign ang_rnd = ang_s[CORDIC_ITERS] + 32'h0000_8000;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_out <= '0;
		end else begin
			ctl_out <= ctl_s[CORDIC_ITERS];
		end
	end

	always_ff @(posedge clk) begin
		bearing <= z_s[CORDIC_ITERS] ? 16'h0 : ang_rnd[31:16];
		yaw_out <= yaw_s[CORDIC_ITERS];
	end

endmodule

FILE: rtl/ehc_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehc_lane
// One yaw lane: wrapped angle between yaw and bearing, or its reverse.
// ----------------------------------------------------------------------------
module ehc_lane (
	input  logic        clk,
	input  logic [15:0] yaw,
	input  logic [15:0] bearing,
	input  logic        active,
	input  logic        fwd_only,
	output logic [15:0] diff_q
);
	import ehc_pkg::*;

	logic [15:0] d, dr, fwd, rev, best;

	always_comb begin
		d   = yaw - bearing;
		dr  = d ^ 16'h8000;   // difference to bearing plus a half turn
		fwd = (d  <= 16'h8000) ? d  : 16'(17'h10000 - {1'b0, d});
		rev = (dr <= 16'h8000) ? dr : 16'(17'h10000 - {1'b0, dr});
		best = (!fwd_only && rev < fwd) ? rev : fwd;
	end

	always_ff @(posedge clk) begin
		diff_q <= active ? best : 16'h0;
	end

endmodule

FILE: rtl/ehc_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ehc_merge
// Sum the lanes, scale by weight and 2*pi, divide by step count, raise to
// the configured power and saturate.
// ----------------------------------------------------------------------------
module ehc_merge (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ehc_pkg::ctl_t                      ctl_in,
	input  logic [ehc_pkg::MAX_STEPS-1:0][15:0] diffs,
	output logic                               cost_valid,
	output logic [31:0]                        cost
);
	import ehc_pkg::*;

	// control per stage: sum, mul1, mul2, quot, est, v, power stages
	ctl_t ctl_sum_s1, ctl_mul_s2, ctl_pp_s3, ctl_q_s4, ctl_est_s5, ctl_v_s6;
	ctl_t ctl_p [0:POW_STAGES];

	logic [19:0] sum_s1;
	logic [35:0] sw_s2;
	logic [44:0] plo_s3, phi_s3;
	logic [31:0] q_s4;
	logic [31:0] q_s5, est_s5;
	logic [31:0] v_s6;
	logic [31:0] v_p [0:POW_STAGES];
	logic [31:0] r_p [0:POW_STAGES];

	logic [19:0] sum_c;
	logic [63:0] num_c;
	logic [64:0] prod_c;
	logic [35:0] en_c;
	logic [31:0] rem_c;

	always_comb begin
		sum_c = '0;
		for (int k = 0; k < MAX_STEPS; k++) begin
			sum_c = sum_c + 20'(diffs[k]);
		end
		num_c = (64'(phi_s3) << 18) + 64'(plo_s3) + (64'(ctl_pp_s3.n) << 31);
		prod_c = 65'(q_s4) * 65'(recip(ctl_q_s4.n));
		en_c  = 36'(est_s5) * 36'(ctl_est_s5.n);
		rem_c = q_s5 - en_c[31:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_sum_s1 <= '0;
			ctl_mul_s2 <= '0;
			ctl_pp_s3  <= '0;
			ctl_q_s4   <= '0;
			ctl_est_s5 <= '0;
			ctl_v_s6   <= '0;
		end else begin
			ctl_sum_s1 <= ctl_in;
			ctl_mul_s2 <= ctl_sum_s1;
			ctl_pp_s3  <= ctl_mul_s2;
			ctl_q_s4   <= ctl_pp_s3;
			ctl_est_s5 <= ctl_q_s4;
			ctl_v_s6   <= ctl_est_s5;
		end
	end

	always_ff @(posedge clk) begin
		sum_s1 <= sum_c;
		sw_s2  <= 36'(sum_s1) * 36'(ctl_sum_s1.weight);
		plo_s3 <= 45'(sw_s2[17:0]) * 45'(TWO_PI_Q24);
		phi_s3 <= 45'(sw_s2[35:18]) * 45'(TWO_PI_Q24);
		q_s4   <= num_c[63:32];
		q_s5   <= q_s4;
		est_s5 <= prod_c[63:32];
		// estimate is at most one short
		v_s6   <= (rem_c >= 32'(ctl_est_s5.n)) ? est_s5 + 32'd1 : est_s5;
	end

	assign ctl_p[0] = ctl_v_s6;
	assign v_p[0]   = v_s6;
	assign r_p[0]   = 32'h0001_0000;

	for (genvar j = 0; j < POW_STAGES; j++) begin : g_pow
		logic [63:0] t;
		logic [47:0] rs;
		assign t  = 64'(r_p[j]) * 64'(v_p[j]) + 64'd32768;
		assign rs = t[63:16];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				ctl_p[j+1] <= '0;
			end else begin
				ctl_p[j+1] <= ctl_p[j];
			end
		end

		always_ff @(posedge clk) begin
			v_p[j+1] <= v_p[j];
			if (3'(j) < ctl_p[j].power) begin
				r_p[j+1] <= (rs[47:32] != 16'h0) ? 32'hFFFF_FFFF : rs[31:0];
			end else begin
				r_p[j+1] <= r_p[j];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cost_valid <= 1'b0;
		end else begin
			cost_valid <= ctl_p[POW_STAGES].valid;
		end
	end

	always_ff @(posedge clk) begin
		cost <= ctl_p[POW_STAGES].zero ? 32'h0 : r_p[POW_STAGES];
	end

endmodule

FILE: rtl/early_heading_cost_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// early_heading_cost_core
// Heading commitment cost of one sampled trajectory per word.
// ----------------------------------------------------------------------------
// The core takes one trajectory word in every cycle (busy stays low) and
// returns its cost, marked by a one-cycle cost_valid; results leave in
// input order and cannot be held off. The cost passes through the input
// register, the 20-stage bearing CORDIC, the lane stage and the scale, divide
// and power pipeline. Write configuration only while no word is in flight.
module early_heading_cost_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [31:0] start_x,
	input  logic signed [31:0] start_y,
	input  logic [15:0]        yaw_step_0,
	input  logic [15:0]        yaw_step_1,
	input  logic [15:0]        yaw_step_2,
	input  logic [15:0]        yaw_step_3,
	input  logic [15:0]        yaw_step_4,
	input  logic [15:0]        yaw_step_5,
	input  logic [15:0]        yaw_step_6,
	input  logic [15:0]        yaw_step_7,
	input  logic [15:0]        yaw_step_8,
	input  logic [15:0]        yaw_step_9,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	output logic               cost_valid,
	output logic [31:0]        cost
);
	import ehc_pkg::*;

	logic               enable_q;
	logic signed [31:0] target_x_q, target_y_q;
	logic [3:0]         early_steps_q;
	logic               forward_only_q;
	logic [15:0]        weight_q;
	logic [2:0]         exponent_q;

	ctl_t               ctl_s0, ctl_c, ctl_l;
	yaw_vec_t           yaw_s0, yaw_c;
	logic signed [32:0] dx_s0, dy_s0;
	logic [15:0]        bearing;
	logic [MAX_STEPS-1:0][15:0] diffs;
	logic [3:0]         n_c;
	logic               accept;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign n_c       = (early_steps_q < 4'(MAX_STEPS)) ? early_steps_q : 4'(MAX_STEPS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q       <= 1'b1;
			target_x_q     <= '0;
			target_y_q     <= '0;
			early_steps_q  <= 4'd10;
			forward_only_q <= 1'b0;
			weight_q       <= 16'd2560;
			exponent_q     <= 3'd1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ENABLE:       enable_q       <= cfg_data[0];
				REG_TARGET_X:     target_x_q     <= cfg_data;
				REG_TARGET_Y:     target_y_q     <= cfg_data;
				REG_EARLY_STEPS:  early_steps_q  <= cfg_data[3:0];
				REG_FORWARD_ONLY: forward_only_q <= cfg_data[0];
				REG_WEIGHT:       weight_q       <= cfg_data[15:0];
				REG_EXPONENT:     exponent_q     <= cfg_data[2:0];
				default:          ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s0 <= '0;
		end else begin
			ctl_s0.valid    <= accept;
			ctl_s0.zero     <= !enable_q || (n_c == 4'd0);
			ctl_s0.fwd_only <= forward_only_q;
			ctl_s0.n        <= n_c;
			ctl_s0.power    <= exponent_q;
			ctl_s0.weight   <= weight_q;
		end
	end

	always_ff @(posedge clk) begin
		dx_s0 <= {target_x_q[31], target_x_q} - {start_x[31], start_x};
		dy_s0 <= {target_y_q[31], target_y_q} - {start_y[31], start_y};
		yaw_s0 <= {yaw_step_9, yaw_step_8, yaw_step_7, yaw_step_6, yaw_step_5,
			yaw_step_4, yaw_step_3, yaw_step_2, yaw_step_1, yaw_step_0};
	end

	ehc_cordic u_cordic (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl_in  (ctl_s0),
		.yaw_in  (yaw_s0),
		.dx      (dx_s0),
		.dy      (dy_s0),
		.ctl_out (ctl_c),
		.yaw_out (yaw_c),
		.bearing (bearing)
	);

	for (genvar k = 0; k < MAX_STEPS; k++) begin : g_lane
		ehc_lane u_lane (
			.clk      (clk),
			.yaw      (yaw_c[k]),
			.bearing  (bearing),
			.active   (4'(k) < ctl_c.n),
			.fwd_only (ctl_c.fwd_only),
			.diff_q   (diffs[k])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_l <= '0;
		end else begin
			ctl_l <= ctl_c;
		end
	end

	ehc_merge u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctl_in     (ctl_l),
		.diffs      (diffs),
		.cost_valid (cost_valid),
		.cost       (cost)
	);

endmodule
